### hw/rtl/kwsc_pkg.sv
// Shared types, constants and helper functions of the keyword substitution cipher.
`timescale 1ns / 1ps
`default_nettype none

package kwsc_pkg;

  localparam int unsigned ALPHA = 26;
  localparam int unsigned IDX_W = 5;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHA - 1);
  localparam logic [IDX_W-1:0] ALPHA_CNT = IDX_W'(ALPHA);

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_FINISH = 2'd1,
    OP_ENC    = 2'd2,
    OP_DEC    = 2'd3
  } opcode_t;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOT_LTR  = 2'd1;
  localparam logic [1:0] STAT_FINISHED = 2'd2;
  localparam logic [1:0] STAT_REJECTED = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic take;         // input word accepted this cycle
    logic ident_step;   // write identity at sweep index
    logic fill_step;    // append unused letter at sweep index
    logic invert_step;  // inverse[forward[i]] = i
    logic clear_build;  // drop used set, fill count and bad flag
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic cnt_last;
    logic key_bad;
  } dp_stat_t;

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] b);
    return (b >= 8'h61) && (b <= 8'h7A);
  endfunction

  // alphabet index of a letter, either case
  function automatic logic [IDX_W-1:0] letter_idx(input logic [7:0] b);
    logic [7:0] d;
    d = is_upper(b) ? (b - 8'h41) : (b - 8'h61);
    return d[IDX_W-1:0];
  endfunction

  // letter through table entry, case kept; others unchanged
  function automatic logic [7:0] map_byte(input logic [7:0] b, input logic [IDX_W-1:0] v);
    logic [7:0] r;
    r = b;
    if (is_upper(b)) begin
      r = 8'h41 + {3'b000, v};
    end else if (is_lower(b)) begin
      r = 8'h61 + {3'b000, v};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/kwsc_if.sv
// Valid/ready channel interfaces for input and result words.
`timescale 1ns / 1ps
`default_nettype none

interface kwsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] in_byte;
  modport source (output valid, output opcode, output in_byte, input ready);
  modport sink   (input valid, input opcode, input in_byte, output ready);
endinterface

interface kwsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  modport source (output valid, output out_byte, output status, input ready);
  modport sink   (input valid, input out_byte, input status, output ready);
endinterface

`default_nettype wire

### hw/rtl/keyword_substitution_cipher.sv
// Top level of the keyword substitution cipher: controller, datapath, checks.
// Result: the result word of an accepted word is in the output register in the cycle after it is taken.
// Throughput: keyword, encrypt and decrypt words one per cycle while the result register
//   is free; a finish word holds the input through the fill sweep and the inversion sweep
//   over 26 table entries, or through the identity sweep alone for a rejected key.
// Reset: synchronous; afterward an identity sweep over 26 table entries loads both tables
//   while ready stays low.
`timescale 1ns / 1ps
`default_nettype none

module keyword_substitution_cipher (
  input  wire              clk,
  input  wire              rst,
  kwsc_in_if.sink          in_ch,
  kwsc_out_if.source       out_ch
);

  kwsc_pkg::ctrl_cmd_t cmd;
  kwsc_pkg::dp_stat_t  stat;

  // Controller owns the input handshake and the sweep sequence.
  kwsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .opcode   (in_ch.opcode),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  // Datapath holds the tables, the key under construction and the result word.
  kwsc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .opcode    (in_ch.opcode),
    .in_byte   (in_ch.in_byte),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .status    (out_ch.status)
  );

  // A word is only taken when its result has a free slot.
  a_room_for_result: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> (!out_ch.valid || out_ch.ready))
    else $error("input accepted while result register is blocked");

  // A finish word starts a sweep, so the next cycle takes no word.
  a_finish_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && (in_ch.opcode == kwsc_pkg::OP_FINISH)) |=> !in_ch.ready)
    else $error("input ready right after a finish word");

  // Result words appear only after an accepted word.
  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready))
    else $error("result word without an accepted input word");

  // Keyword and finish words always carry a zero byte.
  a_key_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready &&
     (in_ch.opcode == kwsc_pkg::OP_KEY || in_ch.opcode == kwsc_pkg::OP_FINISH))
    |=> (out_ch.out_byte == 8'h00))
    else $error("nonzero byte on a key result");

endmodule

`default_nettype wire

### hw/rtl/kwsc_dp.sv
// Datapath: key tables, key build state, sweep counter and output register.
`timescale 1ns / 1ps
`default_nettype none

module kwsc_dp (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                 [1:0] opcode,
  input  wire                 [7:0] in_byte,
  input  wire                       out_ready,
  input  wire kwsc_pkg::ctrl_cmd_t  cmd,
  output kwsc_pkg::dp_stat_t        stat,
  output logic                      out_valid,
  output logic                [7:0] out_byte,
  output logic                [1:0] status
);

  logic [kwsc_pkg::IDX_W-1:0] fwd_tab [kwsc_pkg::ALPHA];
  logic [kwsc_pkg::IDX_W-1:0] inv_tab [kwsc_pkg::ALPHA];
  logic [kwsc_pkg::ALPHA-1:0] used;
  logic [kwsc_pkg::IDX_W-1:0] fill;
  logic                       key_bad;
  logic [kwsc_pkg::IDX_W-1:0] cnt;

  kwsc_pkg::opcode_t          op;
  logic                       letter;
  logic [kwsc_pkg::IDX_W-1:0] idx;
  logic [kwsc_pkg::IDX_W-1:0] fwd_addr;
  logic [kwsc_pkg::IDX_W-1:0] fwd_rd;
  logic [kwsc_pkg::IDX_W-1:0] inv_rd;
  logic                       room;
  logic                       key_add;
  logic                       fill_add;
  logic                       fwd_we;
  logic [kwsc_pkg::IDX_W-1:0] fwd_wa;
  logic [kwsc_pkg::IDX_W-1:0] fwd_wd;
  logic                       inv_we;
  logic [kwsc_pkg::IDX_W-1:0] inv_wa;
  logic [7:0]                 res_byte;
  logic [1:0]                 res_stat;

  always_comb begin
    op       = kwsc_pkg::opcode_t'(opcode);
    letter   = kwsc_pkg::is_upper(in_byte) || kwsc_pkg::is_lower(in_byte);
    idx      = kwsc_pkg::letter_idx(in_byte);
    fwd_addr = cmd.invert_step ? cnt : idx;
    fwd_rd   = fwd_tab[fwd_addr];
    inv_rd   = inv_tab[idx];
    room     = fill < kwsc_pkg::ALPHA_CNT;
    key_add  = cmd.take && (op == kwsc_pkg::OP_KEY) && letter && !used[idx] && room;
    fill_add = cmd.fill_step && !used[cnt] && room;

    fwd_we = 1'b0;
    fwd_wa = fill;
    fwd_wd = idx;
    if (cmd.ident_step) begin
      fwd_we = 1'b1;
      fwd_wa = cnt;
      fwd_wd = cnt;
    end else if (fill_add) begin
      fwd_we = 1'b1;
      fwd_wd = cnt;
    end else if (key_add) begin
      fwd_we = 1'b1;
    end

    inv_we = cmd.ident_step || cmd.invert_step;
    inv_wa = cmd.ident_step ? cnt : fwd_rd;

    res_byte = 8'h00;
    res_stat = kwsc_pkg::STAT_OK;
    unique case (op)
      kwsc_pkg::OP_KEY: begin
        res_stat = letter ? kwsc_pkg::STAT_OK : kwsc_pkg::STAT_NOT_LTR;
      end
      kwsc_pkg::OP_FINISH: begin
        res_stat = key_bad ? kwsc_pkg::STAT_REJECTED : kwsc_pkg::STAT_FINISHED;
      end
      kwsc_pkg::OP_ENC: res_byte = kwsc_pkg::map_byte(in_byte, fwd_rd);
      kwsc_pkg::OP_DEC: res_byte = kwsc_pkg::map_byte(in_byte, inv_rd);
      default: res_byte = 8'h00;
    endcase

    stat.out_free = !out_valid || out_ready;
    stat.cnt_last = cnt == kwsc_pkg::LAST_IDX;
    stat.key_bad  = key_bad;
  end

  // table storage, contents set by the identity sweep after reset
  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_tab[fwd_wa] <= fwd_wd;
    end
    if (inv_we) begin
      inv_tab[inv_wa] <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      fill    <= '0;
      key_bad <= 1'b0;
      cnt     <= '0;
    end else begin
      if (cmd.ident_step || cmd.fill_step || cmd.invert_step) begin
        cnt <= stat.cnt_last ? '0 : cnt + 1'b1;
      end
      if (key_add) begin
        used[idx] <= 1'b1;
        fill      <= fill + 1'b1;
      end
      if (fill_add) begin
        used[cnt] <= 1'b1;
        fill      <= fill + 1'b1;
      end
      if (cmd.take && (op == kwsc_pkg::OP_KEY) && !letter) begin
        key_bad <= 1'b1;
      end
      if (cmd.clear_build) begin
        used    <= '0;
        fill    <= '0;
        key_bad <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      out_byte <= res_byte;
      status   <= res_stat;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/kwsc_ctrl.sv
// Controller: accepts words and sequences the identity, fill and inversion sweeps.
`timescale 1ns / 1ps
`default_nettype none

module kwsc_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  input  wire                 [1:0] opcode,
  input  wire kwsc_pkg::dp_stat_t   stat,
  output logic                      in_ready,
  output kwsc_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_IDENT  = 4'b0010,
    S_FILL   = 4'b0100,
    S_INVERT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    in_ready        = (state == S_IDLE) && stat.out_free;
    cmd.take        = in_valid && in_ready;
    cmd.ident_step  = state == S_IDENT;
    cmd.fill_step   = state == S_FILL;
    cmd.invert_step = state == S_INVERT;
    cmd.clear_build = 1'b0;
    state_next      = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.take && (kwsc_pkg::opcode_t'(opcode) == kwsc_pkg::OP_FINISH)) begin
          state_next = stat.key_bad ? S_IDENT : S_FILL;
        end
      end
      S_IDENT: begin
        if (stat.cnt_last) begin
          state_next      = S_IDLE;
          cmd.clear_build = 1'b1;
        end
      end
      S_FILL: begin
        if (stat.cnt_last) begin
          state_next = S_INVERT;
        end
      end
      S_INVERT: begin
        if (stat.cnt_last) begin
          state_next      = S_IDLE;
          cmd.clear_build = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDENT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire
